@@ hw/rtl/fxalu_pkg.sv @@
// package for the q24.8 fixed-point alu: command codes, widths and shared types
// depends on nothing

package fxalu_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 8;
  localparam int unsigned DivSteps = WordBits + FracBits;

  typedef enum logic [3:0] {
    CmdFromInt   = 4'd0,
    CmdFromFloat = 4'd1,
    CmdToInt     = 4'd2,
    CmdToFloat   = 4'd3,
    CmdAdd       = 4'd4,
    CmdSub       = 4'd5,
    CmdMul       = 4'd6,
    CmdDiv       = 4'd7,
    CmdCmp       = 4'd8,
    CmdMin       = 4'd9,
    CmdMax       = 4'd10,
    CmdInc       = 4'd11,
    CmdDec       = 4'd12
  } cmd_e;

  // one divider stage token handed from cell to cell
  typedef struct packed {
    logic                valid;
    logic [WordBits-1:0] ma;
    logic [WordBits-1:0] mb;
    logic [DivSteps:0]   rem;
    logic [DivSteps-1:0] quo;
    logic                neg;
  } div_tok_t;

  // result item before the final stage
  typedef struct packed {
    logic [WordBits-1:0] result;
    logic                is_equal;
    logic                is_less;
    logic                is_greater;
    logic                overflow;
    logic                div_by_zero;
  } res_t;

endpackage

@@ hw/rtl/fxalu_div_cell.sv @@
// one restoring division cell: brings in one dividend bit, subtracts if it fits
// depends on fxalu_pkg

module fxalu_div_cell #(
  parameter int unsigned Step = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  fxalu_pkg::div_tok_t tok_i,
  output fxalu_pkg::div_tok_t tok_o
);

  localparam int unsigned Steps = fxalu_pkg::DivSteps;
  localparam int unsigned BitIdx = Steps - 1 - Step;

  fxalu_pkg::div_tok_t tok_d, tok_q;
  logic           vld_q;
  logic [Steps:0] shifted;
  logic [Steps:0] diff;
  logic           in_bit;

  // bit of the dividend scaled by the fraction bits
  if (BitIdx >= fxalu_pkg::FracBits) begin : g_bit
    assign in_bit = tok_i.ma[BitIdx - fxalu_pkg::FracBits];
  end else begin : g_pad
    assign in_bit = 1'b0;
  end

  always_comb begin
    shifted = {tok_i.rem[Steps-1:0], in_bit};
    diff    = shifted - {{(Steps + 1 - fxalu_pkg::WordBits){1'b0}}, tok_i.mb};
    tok_d   = tok_i;
    if (!diff[Steps]) begin
      tok_d.rem = diff;
      tok_d.quo = {tok_i.quo[Steps-2:0], 1'b1};
    end else begin
      tok_d.rem = shifted;
      tok_d.quo = {tok_i.quo[Steps-2:0], 1'b0};
    end
  end

  // valid bit under reset, payload free-running when enabled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = vld_q;
  end

endmodule

@@ hw/rtl/fixed_point_q24_8_alu_unit.sv @@
// top level of the q24.8 fixed-point alu
// depends on fxalu_pkg and fxalu_div_cell
//
// usage:
//   items enter on the s_axis group: tdata holds cmd, operand_a, operand_b.
//   results leave on the m_axis group: tdata holds result and the five flags.
//   one item per cycle in sustained flow, as long as the receiver does not
//   stall. every item travels through one pipeline of DivSteps + 3
//   registers (operand stage, a row of 40 division cells, a quotient align
//   stage and a final pack stage; the two-stage multiply runs beside the
//   last cell and the align stage); the division cell row sets the depth.
//   all operations ride the same pipeline, keeping items in order.
//   when the receiver stalls the whole pipeline holds; s_axis_tready follows
//   m_axis_tready or an empty output register, so no item is lost.
//   reset clears every valid bit; payload registers are not reset.

module fixed_point_q24_8_alu_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd [3:0], operand_a [35:4], operand_b [67:36], zero pad [71:68]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result [31:0], is_equal [32], is_less [33], is_greater [34],
  // overflow [35], div_by_zero [36], zero pad [39:37]
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned W  = fxalu_pkg::WordBits;
  localparam int unsigned F  = fxalu_pkg::FracBits;
  localparam int unsigned NS = fxalu_pkg::DivSteps;
  localparam int unsigned Lat = NS + 3;
  localparam logic [W-1:0] FracMask = W'((1 << F) - 1);

  typedef struct packed {
    logic [3:0]   cmd;
    logic [W-1:0] a;
    logic [W-1:0] b;
  } op_t;

  logic en;
  logic [Lat-1:0] vld_q;
  op_t  ops_q [Lat];

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // operand side-line travelling beside the cells
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ops_q[0] <= {s_axis_tdata[3:0], s_axis_tdata[35:4], s_axis_tdata[67:36]};
      for (int i = 1; i < Lat; i++) ops_q[i] <= ops_q[i-1];
    end
  end

  // division cell row fed from stage 0
  fxalu_pkg::div_tok_t tok [NS+1];
  fxalu_pkg::div_tok_t tok_in;
  always_comb begin
    tok_in.valid = vld_q[0];
    tok_in.ma    = ops_q[0].a[W-1] ? W'(-ops_q[0].a) : ops_q[0].a;
    tok_in.mb    = ops_q[0].b[W-1] ? W'(-ops_q[0].b) : ops_q[0].b;
    tok_in.rem   = '0;
    tok_in.quo   = '0;
    tok_in.neg   = ops_q[0].a[W-1] ^ ops_q[0].b[W-1];
  end

  assign tok[0] = tok_in;

  for (genvar g = 0; g < NS; g++) begin : g_div
    fxalu_div_cell #(.Step(g)) u_cell (
      .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
      .tok_i (tok[g]), .tok_o (tok[g+1])
    );
  end

  // multiply: magnitudes at stage NS, product at stage NS+1 beside the quotient
  logic [W-1:0]   mma_q, mmb_q;
  logic [2*W-1:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      mma_q  <= ops_q[NS-1].a[W-1] ? W'(-ops_q[NS-1].a) : ops_q[NS-1].a;
      mmb_q  <= ops_q[NS-1].b[W-1] ? W'(-ops_q[NS-1].b) : ops_q[NS-1].b;
      prod_q <= mma_q * mmb_q;
    end
  end

  // division result aligned: cell row ends at stage NS, hold one more stage
  logic [NS-1:0] quo_q;
  always_ff @(posedge clk_i) begin
    if (en) quo_q <= tok[NS].quo;
  end

  // float to fixed decode
  function automatic logic [W:0] sat_pack(input logic neg, input logic [63:0] mag,
                                          input logic big);
    logic [W:0] r;
    logic [63:0] lim;
    lim = 64'(1) << (W - 1);
    r = '0;
    if (neg) begin
      if (big || mag > lim) r = {1'b1, 1'b1, {(W-1){1'b0}}};
      else r = {1'b0, W'(64'(0) - mag)};
    end else begin
      if (big || mag > lim - 64'd1) r = {1'b1, 1'b0, {(W-1){1'b1}}};
      else r = {1'b0, W'(mag)};
    end
    return r;
  endfunction

  function automatic logic [W:0] from_float(input logic [31:0] bits);
    logic        neg;
    logic [7:0]  ex;
    logic [23:0] sig;
    int          sh;
    logic [63:0] mag;
    neg = bits[31];
    ex  = bits[30:23];
    sig = {1'b0, bits[22:0]};
    mag = '0;
    if (ex == 8'hFF) begin
      if (bits[22:0] != '0) return {1'b1, {W{1'b0}}};
      return sat_pack(neg, 64'd0, 1'b1);
    end
    if (ex == 8'd0) sh = -149 + F;
    else begin
      sig[23] = 1'b1;
      sh = int'(ex) - 150 + F;
    end
    if (sh >= 0) begin
      if (sh + 24 > 63) return sat_pack(neg, 64'd0, sig != '0);
      mag = 64'(sig) << sh;
    end else if (-sh < 25) begin
      mag = (64'(sig) >> (-sh)) + 64'((64'(sig) >> (-sh - 1)) & 64'd1);
    end
    return sat_pack(neg, mag, 1'b0);
  endfunction

  function automatic logic [31:0] to_float(input logic [W-1:0] v);
    logic [W-1:0] m;
    int           p, s;
    logic [W-1:0] rem, half;
    logic [24:0]  mant;
    logic [7:0]   ex;
    m = v[W-1] ? W'(-v) : v;
    p = 0;
    if (m == '0) return 32'd0;
    for (int i = 0; i < W; i++) if (m[i]) p = i;
    ex = 8'(p - F + 127);
    if (p <= 23) mant = 25'(m << (23 - p));
    else begin
      s    = p - 23;
      rem  = m & ((W'(1) << s) - W'(1));
      half = W'(1) << (s - 1);
      mant = 25'(m >> s);
      if (rem > half || (rem == half && mant[0])) mant = mant + 25'd1;
      if (mant[24]) begin
        mant = mant >> 1;
        ex   = ex + 8'd1;
      end
    end
    return {v[W-1], ex, mant[22:0]};
  endfunction

  // every command, conversions included, is resolved in its own stage before the output register
  op_t op;
  fxalu_pkg::res_t res_d, res_q;
  logic [W:0] ff;
  logic [W:0] pk;
  logic signed [W-1:0] sa, sb;
  logic [W-1:0] hi_int;
  logic [W-1:0] int_bias;

  assign op = ops_q[Lat-2];
  assign sa = op.a;
  assign sb = op.b;
  assign hi_int = W'({1'b0, {(W-1){1'b1}}} >> F);

  // bias negative values so the arithmetic shift truncates toward zero
  assign int_bias = op.a + (op.a[W-1] ? FracMask : '0);

  always_comb begin
    res_d = '0;
    ff    = '0;
    pk    = '0;
    case (fxalu_pkg::cmd_e'(op.cmd))
      fxalu_pkg::CmdFromInt: begin
        if (sa > $signed(hi_int) || sa < -$signed(hi_int) - 1) begin
          res_d.overflow = 1'b1;
          res_d.result = sa[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else res_d.result = op.a << F;
      end
      fxalu_pkg::CmdFromFloat: begin
        ff = from_float(op.a);
        res_d.result = ff[W-1:0];
        res_d.overflow = ff[W];
      end
      fxalu_pkg::CmdToInt: res_d.result = W'($signed(int_bias) >>> F);
      fxalu_pkg::CmdToFloat: res_d.result = to_float(op.a);
      fxalu_pkg::CmdAdd: res_d.result = op.a + op.b;
      fxalu_pkg::CmdSub: res_d.result = op.a - op.b;
      fxalu_pkg::CmdMul: begin
        pk = sat_pack(op.a[W-1] ^ op.b[W-1], 64'(prod_q >> F), 1'b0);
        if ((prod_q >> F) >> (W - 1) > 1) pk[W] = 1'b1;
        if (pk[W]) pk[W-1:0] = (op.a[W-1] ^ op.b[W-1]) ? {1'b1, {(W-1){1'b0}}}
                                                         : {1'b0, {(W-1){1'b1}}};
        res_d.result = pk[W-1:0];
        res_d.overflow = pk[W];
      end
      fxalu_pkg::CmdDiv: begin
        if (op.b == '0) begin
          res_d.div_by_zero = 1'b1;
          res_d.result = op.a[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
          pk = sat_pack(op.a[W-1] ^ op.b[W-1], 64'(quo_q), 1'b0);
          res_d.result = pk[W-1:0];
          res_d.overflow = pk[W];
        end
      end
      fxalu_pkg::CmdCmp: begin
        res_d.is_equal   = sa == sb;
        res_d.is_less    = sa < sb;
        res_d.is_greater = sa > sb;
      end
      fxalu_pkg::CmdMin: res_d.result = (sb < sa) ? op.b : op.a;
      fxalu_pkg::CmdMax: res_d.result = (sb > sa) ? op.b : op.a;
      fxalu_pkg::CmdInc: res_d.result = op.a + W'(1);
      fxalu_pkg::CmdDec: res_d.result = op.a - W'(1);
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) res_q <= res_d;
  end

  assign m_axis_tvalid = vld_q[Lat-1];
  assign m_axis_tdata  = {3'b000, res_q.div_by_zero, res_q.overflow, res_q.is_greater,
                          res_q.is_less, res_q.is_equal, res_q.result};

  // checks
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(vld_q))
    else $error("pipeline moved under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("not ready with empty output");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $countones({res_q.is_equal, res_q.is_less, res_q.is_greater}) <= 1)
    else $error("compare flags conflict");

endmodule

@@ tb/fixed_point_q24_8_alu_unit_test.sv @@
// self-checking testbench for the q24.8 fixed-point alu: directed and random items,
// random idling on both sides, a long receiver hold-off; depends on fxalu_pkg and the rtl

module fixed_point_q24_8_alu_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] result;
    logic        is_equal;
    logic        is_less;
    logic        is_greater;
    logic        overflow;
    logic        div_by_zero;
  } alu_res_t;

  typedef struct packed {
    fxalu_pkg::cmd_e cmd;
    logic [31:0]     a;
    logic [31:0]     b;
  } alu_op_t;

  localparam longint MaxPos = 64'sh7fffffff;
  localparam int Latency = 43;
  localparam longint CycleLimit = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  alu_op_t  pending_ops[$];
  alu_res_t expected_res[$];
  int       fail_count;
  bit       stim_done;
  bit       calm;
  bit       hold_on;
  longint   cycle_count;

  fixed_point_q24_8_alu_unit uut (.*);

  // saturate a signed magnitude into the word range
  function automatic logic [31:0] sat_pack(bit neg, logic [127:0] mag, ref bit ovf);
    if (neg) begin
      if (mag > 128'h80000000) begin
        ovf = 1;
        return 32'h80000000;
      end
      return 32'(-mag);
    end
    if (mag > 128'h7fffffff) begin
      ovf = 1;
      return 32'h7fffffff;
    end
    return mag[31:0];
  endfunction

  // ieee single into fixed, rounding half away from zero
  function automatic logic [31:0] float_to_fixed(logic [31:0] bits, ref bit ovf);
    bit neg;
    int ex;
    int sh;
    logic [127:0] sig;
    logic [127:0] mag;
    neg = bits[31];
    ex = bits[30:23];
    sig = bits[22:0];
    if (ex == 255) begin
      if (sig != 0) begin
        ovf = 1;
        return 0;
      end
      return sat_pack(neg, 128'h1_0000_0000, ovf);
    end
    if (ex == 0) sh = -149 + fxalu_pkg::FracBits;
    else begin
      sig[23] = 1;
      sh = ex - 150 + fxalu_pkg::FracBits;
    end
    if (sh >= 0) begin
      if (sh > 60) mag = (sig != 0) ? 128'h1_0000_0000 : 0;
      else mag = sig << sh;
    end else if (-sh >= 25) mag = 0;
    else mag = (sig >> -sh) + ((sig >> (-sh - 1)) & 1);
    return sat_pack(neg, mag, ovf);
  endfunction

  // fixed into ieee single, round to nearest even
  function automatic logic [31:0] fixed_to_float(longint v);
    logic [63:0] m;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] half;
    int p;
    int s;
    logic [31:0] ex;
    m = v < 0 ? -v : v;
    if (m == 0) return 0;
    p = 63;
    while (!m[p]) p--;
    ex = p - fxalu_pkg::FracBits + 127;
    if (p <= 23) mant = m << (23 - p);
    else begin
      s = p - 23;
      rem = m & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      mant = m >> s;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == (64'd1 << 24)) begin
        mant >>= 1;
        ex++;
      end
    end
    return {v < 0, ex[7:0], mant[22:0]};
  endfunction

  function automatic alu_res_t predict_alu(alu_op_t op);
    alu_res_t r;
    longint a;
    longint b;
    logic [127:0] ma;
    logic [127:0] mb;
    bit ovf;
    a = longint'($signed(op.a));
    b = longint'($signed(op.b));
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    r = '0;
    ovf = 0;
    case (op.cmd)
      fxalu_pkg::CmdFromInt: begin
        if (a > (MaxPos >>> fxalu_pkg::FracBits)
            || a < -(MaxPos >>> fxalu_pkg::FracBits) - 1) begin
          r.result = a < 0 ? 32'h80000000 : 32'h7fffffff;
          ovf = 1;
        end else r.result = op.a << fxalu_pkg::FracBits;
      end
      fxalu_pkg::CmdFromFloat: r.result = float_to_fixed(op.a, ovf);
      fxalu_pkg::CmdToInt: r.result = 32'(a / 256);
      fxalu_pkg::CmdToFloat: r.result = fixed_to_float(a);
      fxalu_pkg::CmdAdd: r.result = op.a + op.b;
      fxalu_pkg::CmdSub: r.result = op.a - op.b;
      fxalu_pkg::CmdMul:
        r.result = sat_pack((a < 0) != (b < 0), (ma * mb) >> fxalu_pkg::FracBits, ovf);
      fxalu_pkg::CmdDiv: begin
        if (b == 0) begin
          r.div_by_zero = 1;
          r.result = a < 0 ? 32'h80000000 : 32'h7fffffff;
        end else r.result = sat_pack((a < 0) != (b < 0),
                                     (ma << fxalu_pkg::FracBits) / mb, ovf);
      end
      fxalu_pkg::CmdCmp: begin
        r.is_equal = a == b;
        r.is_less = a < b;
        r.is_greater = a > b;
      end
      fxalu_pkg::CmdMin: r.result = b < a ? op.b : op.a;
      fxalu_pkg::CmdMax: r.result = b > a ? op.b : op.a;
      fxalu_pkg::CmdInc: r.result = op.a + 1;
      fxalu_pkg::CmdDec: r.result = op.a - 1;
      default: r = '0;
    endcase
    r.overflow = ovf;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 1024) - 512;
      default: return $urandom;
    endcase
  endfunction

  // clock and the single reset
  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
  end

  // stimulus, idling stops once the last part of the items remains
  initial begin
    logic [31:0] edge_vals[8] = '{0, 1, 32'hffffffff, 32'h7fffffff, 32'h80000000,
                                  32'h100, 32'hffffff00, 32'h007fffff};
    alu_op_t op;
    stim_done = 0;
    calm = 0;
    for (int c = 0; c <= 12; c++)
      pending_ops.push_back('{fxalu_pkg::cmd_e'(c), edge_vals[c % 8],
                              edge_vals[(c + 3) % 8]});
    pending_ops.push_back('{fxalu_pkg::CmdDiv, 32'h100, 32'h0});
    pending_ops.push_back('{fxalu_pkg::CmdDiv, 32'h80000000, 32'h0});
    pending_ops.push_back('{fxalu_pkg::CmdFromFloat, 32'h7fc00000, 0});
    pending_ops.push_back('{fxalu_pkg::CmdFromFloat, 32'hff800000, 0});
    pending_ops.push_back('{fxalu_pkg::CmdFromFloat, 32'h7f800000, 0});
    pending_ops.push_back('{fxalu_pkg::CmdFromFloat, 32'h80000000, 0});
    pending_ops.push_back('{fxalu_pkg::CmdFromFloat, 32'h3b000000, 0});
    pending_ops.push_back('{fxalu_pkg::CmdFromFloat, 32'hbb000000, 0});
    pending_ops.push_back('{fxalu_pkg::CmdToFloat, 32'h0, 0});
    pending_ops.push_back('{fxalu_pkg::CmdToFloat, 32'h01ffffff, 0});
    pending_ops.push_back('{fxalu_pkg::CmdCmp, 32'h5, 32'h5});
    pending_ops.push_back('{fxalu_pkg::CmdToInt, 32'hffffff01, 0});
    for (int i = 0; i < 400; i++) begin
      op.cmd = fxalu_pkg::cmd_e'($urandom_range(0, 12));
      op.a = rand_word();
      op.b = ($urandom_range(0, 15) == 0) ? 32'h0 : rand_word();
      if (op.cmd == fxalu_pkg::CmdFromFloat && $urandom_range(0, 1))
        op.a = {op.a[31], 8'($urandom_range(100, 160)), op.a[22:0]};
      pending_ops.push_back(op);
    end
    stim_done = 1;
    while (pending_ops.size() >= 100) @(posedge clk_i);
    calm = 1;
  end

  // driver with idle bursts between items
  int src_idle;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 0;
      s_axis_tdata <= '0;
      src_idle = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_res.push_back(predict_alu(alu_op_t'({s_axis_tdata[3:0],
                               s_axis_tdata[35:4], s_axis_tdata[67:36]})));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_idle > 0 && !calm) begin
          src_idle--;
          s_axis_tvalid <= 0;
        end else if (pending_ops.size() > 0) begin
          alu_op_t op;
          op = pending_ops.pop_front();
          s_axis_tvalid <= 1;
          s_axis_tdata <= {4'b0, op.b, op.a, op.cmd};
          if (!calm && $urandom_range(0, 7) == 0) src_idle = $urandom_range(1, 19);
        end else s_axis_tvalid <= 0;
      end
    end
  end

  // long receiver hold-off early on, counted on its own
  int hold_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left = 0;
      hold_on <= 0;
    end else begin
      if (cycle_count == 40) hold_left = 150;
      else if (hold_left > 0) hold_left--;
      hold_on <= hold_left > 0;
    end
  end

  // receiver idling in random bursts
  int idle_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 0;
      idle_left = 0;
    end else begin
      if (!calm && idle_left == 0 && $urandom_range(0, 9) == 0)
        idle_left = $urandom_range(1, 19);
      if (hold_on) m_axis_tready <= 0;
      else if (idle_left > 0) begin
        idle_left--;
        m_axis_tready <= 0;
      end else m_axis_tready <= 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      alu_res_t got;
      alu_res_t want;
      got.result      = m_axis_tdata[31:0];
      got.is_equal    = m_axis_tdata[32];
      got.is_less     = m_axis_tdata[33];
      got.is_greater  = m_axis_tdata[34];
      got.overflow    = m_axis_tdata[35];
      got.div_by_zero = m_axis_tdata[36];
      if (expected_res.size() == 0) begin
        $error("result with no item outstanding: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_res.pop_front();
        if (got.result !== want.result) begin
          $error("result: expected %h actual %h", want.result, got.result);
          fail_count++;
        end
        if (got.is_equal !== want.is_equal) begin
          $error("is_equal: expected %b actual %b", want.is_equal, got.is_equal);
          fail_count++;
        end
        if (got.is_less !== want.is_less) begin
          $error("is_less: expected %b actual %b", want.is_less, got.is_less);
          fail_count++;
        end
        if (got.is_greater !== want.is_greater) begin
          $error("is_greater: expected %b actual %b", want.is_greater, got.is_greater);
          fail_count++;
        end
        if (got.overflow !== want.overflow) begin
          $error("overflow: expected %b actual %b", want.overflow, got.overflow);
          fail_count++;
        end
        if (got.div_by_zero !== want.div_by_zero) begin
          $error("div_by_zero: expected %b actual %b", want.div_by_zero, got.div_by_zero);
          fail_count++;
        end
      end
    end
  end

  // cycle counter and end of run
  initial begin
    cycle_count = 0;
    fail_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
      if (stim_done && pending_ops.size() == 0 && !s_axis_tvalid
          && expected_res.size() == 0) begin
        repeat (Latency + 10) @(posedge clk_i);
        if (fail_count == 0 && expected_res.size() == 0) begin
          $display("Test completed successfully");
        end else begin
          $display("Test completed with failures");
        end
        $finish;
      end
    end
  end

endmodule
